// File: hdl/pihc_pkg.sv
// pihc_pkg: shared types, constants and hash step functions for the page integrity
// hash checker; no dependencies, imported by every module of the block
package pihc_pkg;

	localparam int DATA_W = 8;
	localparam int PAGE_W = 10;
	localparam int HASH_W = 64;

	localparam logic [HASH_W-1:0] FNV_SEED   = 64'hcbf29ce484222325;
	localparam logic [HASH_W-1:0] HASH_PRIME = 64'h00000100000001b3;
	localparam int ROT_LEFT  = 5;
	localparam int ROT_RIGHT = HASH_W - ROT_LEFT;

	localparam logic MODE_BASELINE = 1'b0;
	localparam logic MODE_VERIFY   = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic [PAGE_W-1:0] page_index;
		logic              last_byte;
	} pihc_in_t;

	typedef struct packed {
		logic [PAGE_W-1:0] result_page;
		logic [HASH_W-1:0] hash_fnv;
		logic [HASH_W-1:0] hash_rotate;
		logic [HASH_W-1:0] hash_mixed_xor;
		logic [HASH_W-1:0] hash_mixed_sum;
		logic              baseline_known;
		logic              mismatch;
	} pihc_out_t;

	// one baseline store entry
	typedef struct packed {
		logic              valid;
		logic [HASH_W-1:0] fnv;
		logic [HASH_W-1:0] rot;
	} pihc_entry_t;

	// multiply by the fnv prime, 2^40 + 0x1b3, as a shift-add
	function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
		fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
			input logic [DATA_W-1:0] b);
		fnv_step = fnv_mul(h ^ HASH_W'(b));
	endfunction

	function automatic logic [HASH_W-1:0] rot_step(input logic [HASH_W-1:0] h,
			input logic [DATA_W-1:0] b);
		logic [HASH_W-1:0] s;
		s = h + HASH_W'(b);
		rot_step = (s << ROT_LEFT) | (s >> ROT_RIGHT);
	endfunction

endpackage

// File: hdl/pihc_hash_unit.sv
// pihc_hash_unit: running fnv-1a and add-rotate hash registers with their byte step
// depends on pihc_pkg
module pihc_hash_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [pihc_pkg::DATA_W-1:0] data_byte,
	input  logic                        last_byte,
	output logic [pihc_pkg::HASH_W-1:0] fnv_next,
	output logic [pihc_pkg::HASH_W-1:0] rot_next
);
	import pihc_pkg::*;

	logic [HASH_W-1:0] fnv_q;
	logic [HASH_W-1:0] rot_q;

	assign fnv_next = fnv_step(fnv_q, data_byte);
	assign rot_next = rot_step(rot_q, data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fnv_q <= FNV_SEED;
			rot_q <= HASH_PRIME;
		end else if (step) begin
			// restart from the seeds once a page closes
			fnv_q <= last_byte ? FNV_SEED : fnv_next;
			rot_q <= last_byte ? HASH_PRIME : rot_next;
		end
	end

endmodule

// File: hdl/pihc_baseline_store.sv
// pihc_baseline_store: per-page baseline memory with valid flag, clearing sweep after
// reset and forwarding of the latest write; depends on pihc_pkg
module pihc_baseline_store #(
	parameter int PAGE_COUNT = 1024,
	parameter int ADDR_W     = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  logic [ADDR_W-1:0]       rd_addr,
	output pihc_pkg::pihc_entry_t   rd_entry,
	input  logic                    wr_en,
	input  logic [ADDR_W-1:0]       wr_addr,
	input  pihc_pkg::pihc_entry_t   wr_data,
	output logic                    busy
);
	import pihc_pkg::*;

	pihc_entry_t       mem [PAGE_COUNT];
	pihc_entry_t       rd_q;
	logic [ADDR_W-1:0] rd_addr_q;
	pihc_entry_t       byp_q;
	logic [ADDR_W-1:0] byp_addr_q;
	logic              byp_valid_q;
	logic              clr_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	pihc_entry_t       mem_wd;

	assign busy = clr_q;

	always_comb begin
		mem_we = wr_en;
		mem_wa = wr_addr;
		mem_wd = wr_data;
		if (clr_q) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
			mem_wd = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (rd_en) begin
			rd_q      <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (wr_en && !clr_q) begin
			byp_q      <= wr_data;
			byp_addr_q <= wr_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			byp_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
				if (clr_cnt_q == ADDR_W'(PAGE_COUNT - 1))
					clr_q <= 1'b0;
			end
			if (wr_en && !clr_q)
				byp_valid_q <= 1'b1;
		end
	end

	// a write landing on the same edge as the read is not in rd_q yet
	assign rd_entry = (byp_valid_q && byp_addr_q == rd_addr_q) ? byp_q : rd_q;

endmodule

// File: hdl/page_integrity_hash_checker_core.sv
// page_integrity_hash_checker_core: top level of the page integrity hash checker
// depends on pihc_pkg, pihc_hash_unit and pihc_baseline_store
//
// Takes one page byte per transaction and folds it into two 64-bit hashes, fnv-1a and
// add-rotate-left-by-5 seeded with the fnv prime. A byte marked last closes the page:
// one result transaction follows with both hashes, their xor and their sum, and the
// baseline status. With check_mode 0 the hash pair is stored as the page baseline and
// the page is marked known; with check_mode 1 it is compared against a known baseline
// and mismatch is raised on any difference. Pages at or beyond PAGE_COUNT never hold a
// baseline but are still reported. Throughput is one byte per clock, set by the
// combinational hash step; byte_ready drops while the baseline clear runs or while a
// result is stalled at the output with another closed page waiting behind it. The edge
// that accepts a last byte registers the hashes into stage 1 and reads the baseline
// memory; once stage 1 advances, the compare is loaded into the output register. After
// reset the block sweeps the baseline memory to clear the valid flags, one entry per
// clock, so byte_ready stays low until the sweep ends; configuration writes are taken at
// any time and must only be made while idle.
module page_integrity_hash_checker_core #(
	parameter int PAGE_COUNT = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	// byte channel
	input  logic                byte_valid,
	output logic                byte_ready,
	input  pihc_pkg::pihc_in_t  byte_data,
	// result channel
	output logic                result_valid,
	input  logic                result_ready,
	output pihc_pkg::pihc_out_t result_data,
	// configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);
	import pihc_pkg::*;

	localparam int ADDR_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int EXT_W  = (ADDR_W > PAGE_W) ? ADDR_W : PAGE_W;

	logic              check_mode_q;

	// input side
	logic              byte_acc;
	logic              close_page;
	logic [HASH_W-1:0] fnv_next;
	logic [HASH_W-1:0] rot_next;
	logic [EXT_W-1:0]  page_ext;
	logic [ADDR_W-1:0] page_addr;
	logic              page_in_range;

	// stage 1: closed page waiting on its baseline read
	logic              valid_s1;
	logic [PAGE_W-1:0] page_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              in_range_s1;
	logic [HASH_W-1:0] fnv_s1;
	logic [HASH_W-1:0] rot_s1;
	logic              adv_s1;

	// baseline store
	pihc_entry_t       base_entry;
	pihc_entry_t       wr_entry;
	logic              wr_en;
	logic              store_busy;

	// result computation and output register
	logic              known;
	logic              differs;
	pihc_out_t         result_next;
	pihc_out_t         result_q;
	logic              result_valid_q;

	// config register is always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			check_mode_q <= MODE_BASELINE;
		else if (cfg_valid)
			check_mode_q <= cfg_data;
	end

	// stage 1 moves on whenever the output register is free or being drained
	assign adv_s1     = !result_valid_q || result_ready;
	assign byte_ready = !store_busy && (!valid_s1 || adv_s1);
	assign byte_acc   = byte_valid && byte_ready;
	assign close_page = byte_acc && byte_data.last_byte;

	pihc_hash_unit u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (byte_acc),
		.data_byte (byte_data.data_byte),
		.last_byte (byte_data.last_byte),
		.fnv_next  (fnv_next),
		.rot_next  (rot_next)
	);

	// page index to memory address, range check against the configured depth
	assign page_ext      = EXT_W'(byte_data.page_index);
	assign page_addr     = page_ext[ADDR_W-1:0];
	assign page_in_range = 32'(byte_data.page_index) < 32'(PAGE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (close_page)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (close_page) begin
			page_s1     <= byte_data.page_index;
			addr_s1     <= page_addr;
			in_range_s1 <= page_in_range;
			fnv_s1      <= fnv_next;
			rot_s1      <= rot_next;
		end
	end

	// baseline mode stores the pair for in-range pages as the result leaves stage 1
	assign wr_en    = valid_s1 && adv_s1 && in_range_s1 && (check_mode_q == MODE_BASELINE);
	assign wr_entry = '{valid: 1'b1, fnv: fnv_s1, rot: rot_s1};

	pihc_baseline_store #(
		.PAGE_COUNT (PAGE_COUNT),
		.ADDR_W     (ADDR_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (close_page),
		.rd_addr  (page_addr),
		.rd_entry (base_entry),
		.wr_en    (wr_en),
		.wr_addr  (addr_s1),
		.wr_data  (wr_entry),
		.busy     (store_busy)
	);

	// known reflects the store before this result's own write
	assign known   = in_range_s1 && base_entry.valid;
	assign differs = (check_mode_q == MODE_VERIFY) && known &&
		((base_entry.fnv != fnv_s1) || (base_entry.rot != rot_s1));

	always_comb begin
		result_next.result_page    = page_s1;
		result_next.hash_fnv       = fnv_s1;
		result_next.hash_rotate    = rot_s1;
		result_next.hash_mixed_xor = fnv_s1 ^ rot_s1;
		result_next.hash_mixed_sum = fnv_s1 + rot_s1;
		result_next.baseline_known = known;
		result_next.mismatch       = differs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (adv_s1)
			result_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1)
			result_q <= result_next;
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

`ifndef NO_ASSERTIONS
	// no byte transaction is taken while the valid flags are being swept
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		store_busy |-> !byte_ready)
		else $error("byte accepted during baseline clear");

	// verify mode never overwrites a baseline
	a_no_write_in_verify: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (check_mode_q == MODE_BASELINE))
		else $error("baseline written in verify mode");

	// a mismatch needs a known baseline and verify mode
	a_mismatch_known: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_data.mismatch) |->
			(result_data.baseline_known && check_mode_q == MODE_VERIFY))
		else $error("mismatch without known baseline in verify mode");

	// a page just stored in baseline mode reads back as known on the next close
	a_store_then_known: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && close_page && page_addr == addr_s1 && page_in_range) |=>
			(valid_s1 && known))
		else $error("back-to-back baseline not forwarded");
`endif

endmodule
